@@ rtl/nfr_pkg.sv @@
// Shared types and constants for the frame receiver.
// Used by nfr_cfg, nfr_parser and npi_frame_receiver_core; no dependencies.
package nfr_pkg;

    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_HUNT_LIMIT  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_STORE_LIMIT = 2'd2;

    localparam logic [7:0]  START_BYTE_RESET  = 8'd254;
    localparam logic [3:0]  HUNT_LIMIT_RESET  = 4'd9;
    localparam logic [15:0] STORE_LIMIT_RESET = 16'd128;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHECK = 2'd1,
        ST_NO_START  = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN_LO  = 7'b0000010,
        PH_LEN_HI  = 7'b0000100,
        PH_CMD0    = 7'b0001000,
        PH_CMD1    = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CHECK   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_byte_value;
        logic [3:0]  hunt_limit;
        logic [15:0] store_limit;
    } cfg_t;

    typedef struct packed {
        logic        store_valid;
        logic [15:0] store_index;
        logic [7:0]  store_value;
        logic        frame_end;
        status_t     frame_status;
        logic [15:0] payload_length;
    } result_t;

endpackage

@@ rtl/nfr_cfg.sv @@
// Configuration register file of the frame receiver.
// Depends on nfr_pkg for the register indexes, reset values and cfg_t.
module nfr_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [nfr_pkg::CfgIndexWidth-1:0]  wr_index,
    input  logic [15:0]                        wr_data,
    output nfr_pkg::cfg_t                      cfg
);

    nfr_pkg::cfg_t cfg_reg;
    nfr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                nfr_pkg::CFG_START_BYTE:  cfg_next.start_byte_value = wr_data[7:0];
                nfr_pkg::CFG_HUNT_LIMIT:  cfg_next.hunt_limit = wr_data[3:0];
                nfr_pkg::CFG_STORE_LIMIT: cfg_next.store_limit = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte_value <= nfr_pkg::START_BYTE_RESET;
            cfg_reg.hunt_limit       <= nfr_pkg::HUNT_LIMIT_RESET;
            cfg_reg.store_limit      <= nfr_pkg::STORE_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/nfr_parser.sv @@
// Frame state machine: hunts for the start byte, tracks header, payload and check byte.
// Depends on nfr_pkg for phase_t, status_t, cfg_t and result_t.
module nfr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  nfr_pkg::cfg_t    cfg,
    output nfr_pkg::result_t result
);

    nfr_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hunt_count_reg, hunt_count_next;
    logic [7:0]  check_reg, check_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] left_reg, left_next;
    logic [16:0] count_reg, count_next;

    logic        header_store;
    logic        limited_store;
    logic        frame_end;
    logic [4:0]  seen;
    logic [15:0] left_dec;
    logic [16:0] count_inc;

    always_comb begin
        phase_next      = phase_reg;
        hunt_count_next = hunt_count_reg;
        check_next      = check_reg;
        length_next     = length_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        result          = '0;
        header_store    = 1'b0;
        limited_store   = 1'b0;
        frame_end       = 1'b0;
        seen            = {1'b0, hunt_count_reg} + 5'd1;
        left_dec        = left_reg - 16'd1;
        count_inc       = count_reg + 17'd1;

        unique case (phase_reg)
            nfr_pkg::PH_LEN_LO: begin
                length_next  = {length_reg[15:8], rx_byte};
                header_store = 1'b1;
                phase_next   = nfr_pkg::PH_LEN_HI;
            end
            nfr_pkg::PH_LEN_HI: begin
                length_next  = {rx_byte, length_reg[7:0]};
                header_store = 1'b1;
                phase_next   = nfr_pkg::PH_CMD0;
            end
            nfr_pkg::PH_CMD0: begin
                header_store = 1'b1;
                phase_next   = nfr_pkg::PH_CMD1;
            end
            nfr_pkg::PH_CMD1: begin
                header_store = 1'b1;
                left_next    = length_reg;
                phase_next   = (length_reg == 16'd0) ? nfr_pkg::PH_CHECK : nfr_pkg::PH_PAYLOAD;
            end
            nfr_pkg::PH_PAYLOAD: begin
                limited_store = 1'b1;
                left_next     = left_dec;
                if (left_dec == 16'd0) begin
                    phase_next = nfr_pkg::PH_CHECK;
                end
            end
            nfr_pkg::PH_CHECK: begin
                limited_store         = 1'b1;
                frame_end             = 1'b1;
                result.frame_end      = 1'b1;
                result.frame_status   = (rx_byte == check_reg) ? nfr_pkg::ST_OK
                                                               : nfr_pkg::ST_BAD_CHECK;
                result.payload_length = length_reg;
            end
            default: begin
                if (seen > {1'b0, cfg.hunt_limit}) begin
                    result.frame_end    = 1'b1;
                    result.frame_status = nfr_pkg::ST_NO_START;
                    phase_next          = nfr_pkg::PH_HUNT;
                    hunt_count_next     = '0;
                    check_next          = '0;
                    length_next         = '0;
                    left_next           = '0;
                    count_next          = '0;
                end else if (rx_byte == cfg.start_byte_value) begin
                    result.store_valid = 1'b1;
                    result.store_value = rx_byte;
                    phase_next         = nfr_pkg::PH_LEN_LO;
                    hunt_count_next    = '0;
                    check_next         = '0;
                    length_next        = '0;
                    left_next          = '0;
                    count_next         = 17'd1;
                end else begin
                    hunt_count_next = seen[3:0];
                end
            end
        endcase

        if (header_store || limited_store) begin
            if (!frame_end) begin
                check_next = check_reg ^ rx_byte;
            end
            count_next = count_inc;
            if (header_store || (count_inc <= {1'b0, cfg.store_limit})) begin
                result.store_valid = 1'b1;
                result.store_index = count_reg[15:0];
                result.store_value = rx_byte;
            end
            if (frame_end) begin
                phase_next      = nfr_pkg::PH_HUNT;
                hunt_count_next = '0;
                check_next      = '0;
                length_next     = '0;
                left_next       = '0;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= nfr_pkg::PH_HUNT;
            hunt_count_reg <= '0;
            check_reg      <= '0;
            length_reg     <= '0;
            left_reg       <= '0;
            count_reg      <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            hunt_count_reg <= hunt_count_next;
            check_reg      <= check_next;
            length_reg     <= length_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
        end
    end

endmodule

@@ rtl/npi_frame_receiver_core.sv @@
// Top level of the frame receiver: input and result registers around the parser.
// Depends on nfr_pkg, nfr_cfg and nfr_parser.
//
// Received bytes enter on the s_ channel, one beat per byte, and every byte
// yields exactly one result beat on the m_ channel. A result carries the
// buffer write (store_valid, store_index, store_value) and, on the last byte
// of a frame attempt, frame_end with its status and the header's payload
// length. Configuration registers are written through the cfg_ channel,
// which is always ready; writes belong in idle periods and affect the next
// byte that enters the parser.
// A byte accepted on s_ is held in the input register, passes the parser
// combinationally and is registered in the result register, which presents
// it on m_. One byte per cycle is sustained while m_ready stays high: the
// parser state update is combinational logic between the two registers.
// When m_ready is low the result register holds, the input register fills,
// and s_ready drops only once both are occupied. Reset returns the parser to
// hunting for the start byte, empties both registers and restores the
// default start byte, hunt limit and storage limit.
module npi_frame_receiver_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_store_valid,
    output logic [15:0]                        m_store_index,
    output logic [7:0]                         m_store_value,
    output logic                               m_frame_end,
    output logic [1:0]                         m_frame_status,
    output logic [15:0]                        m_payload_length,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nfr_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [15:0]                        cfg_data
);

    nfr_pkg::cfg_t    cfg;
    nfr_pkg::result_t result;
    nfr_pkg::result_t out_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       step;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;

    nfr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    nfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_store_valid    = out_reg.store_valid;
    assign m_store_index    = out_reg.store_index;
    assign m_store_value    = out_reg.store_value;
    assign m_frame_end      = out_reg.frame_end;
    assign m_frame_status   = out_reg.frame_status;
    assign m_payload_length = out_reg.payload_length;

endmodule

@@ bench/npi_frame_receiver_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for npi_frame_receiver_core: framed byte streams with random gaps,
// each result beat checked against a cycle-free model of the deframer.
// Depends on nfr_pkg and the RTL of npi_frame_receiver_core.
module npi_frame_receiver_core_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BYTES = 150;
    localparam int MAX_REPORTS = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_store_valid;
    logic [15:0] m_store_index;
    logic [7:0]  m_store_value;
    logic        m_frame_end;
    logic [1:0]  m_frame_status;
    logic [15:0] m_payload_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [nfr_pkg::CfgIndexWidth-1:0] cfg_index = nfr_pkg::CFG_START_BYTE;
    logic [15:0] cfg_data = 16'd0;

    logic [7:0]       rx_stream[$];
    nfr_pkg::result_t results_due[$];
    int          bytes_queued = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          send_idle_pct = 27;
    int          recv_idle_pct = 48;
    int unsigned cycle_count = 0;

    nfr_pkg::cfg_t   active_cfg = '{nfr_pkg::START_BYTE_RESET, nfr_pkg::HUNT_LIMIT_RESET,
                                    nfr_pkg::STORE_LIMIT_RESET};
    nfr_pkg::phase_t rx_phase = nfr_pkg::PH_HUNT;
    logic [3:0]  hunt_seen = 4'd0;
    logic [7:0]  check_acc = 8'd0;
    logic [15:0] hdr_length = 16'd0;
    logic [15:0] payload_remaining = 16'd0;
    logic [16:0] frame_count = 17'd0;

    npi_frame_receiver_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_store_valid    (m_store_valid),
        .m_store_index    (m_store_index),
        .m_store_value    (m_store_value),
        .m_frame_end      (m_frame_end),
        .m_frame_status   (m_frame_status),
        .m_payload_length (m_payload_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_frame_state();
        rx_phase = nfr_pkg::PH_HUNT;
        hunt_seen = 4'd0;
        check_acc = 8'd0;
        hdr_length = 16'd0;
        payload_remaining = 16'd0;
        frame_count = 17'd0;
    endfunction

    function automatic nfr_pkg::result_t deframe_byte(input logic [7:0] rx);
        nfr_pkg::result_t r;
        logic        in_header;
        logic        in_body;
        logic [4:0]  seen;
        logic [16:0] slot;
        r = '0;
        in_header = 1'b0;
        in_body = 1'b0;
        case (rx_phase)
            nfr_pkg::PH_LEN_LO: begin
                hdr_length[7:0] = rx;
                in_header = 1'b1;
                rx_phase = nfr_pkg::PH_LEN_HI;
            end
            nfr_pkg::PH_LEN_HI: begin
                hdr_length[15:8] = rx;
                in_header = 1'b1;
                rx_phase = nfr_pkg::PH_CMD0;
            end
            nfr_pkg::PH_CMD0: begin
                in_header = 1'b1;
                rx_phase = nfr_pkg::PH_CMD1;
            end
            nfr_pkg::PH_CMD1: begin
                in_header = 1'b1;
                payload_remaining = hdr_length;
                rx_phase = (hdr_length == 16'd0) ? nfr_pkg::PH_CHECK : nfr_pkg::PH_PAYLOAD;
            end
            nfr_pkg::PH_PAYLOAD: begin
                in_body = 1'b1;
                payload_remaining = payload_remaining - 16'd1;
                if (payload_remaining == 16'd0) begin
                    rx_phase = nfr_pkg::PH_CHECK;
                end
            end
            nfr_pkg::PH_CHECK: begin
                in_body = 1'b1;
                r.frame_end = 1'b1;
                if (rx == check_acc) begin
                    r.frame_status = nfr_pkg::ST_OK;
                end else begin
                    r.frame_status = nfr_pkg::ST_BAD_CHECK;
                end
                r.payload_length = hdr_length;
            end
            default: begin
                seen = {1'b0, hunt_seen} + 5'd1;
                if (seen > {1'b0, active_cfg.hunt_limit}) begin
                    r.frame_end = 1'b1;
                    r.frame_status = nfr_pkg::ST_NO_START;
                    clear_frame_state();
                end else if (rx == active_cfg.start_byte_value) begin
                    r.store_valid = 1'b1;
                    r.store_index = 16'd0;
                    r.store_value = rx;
                    clear_frame_state();
                    frame_count = 17'd1;
                    rx_phase = nfr_pkg::PH_LEN_LO;
                end else begin
                    hunt_seen = seen[3:0];
                end
            end
        endcase
        if (in_header || in_body) begin
            if (!r.frame_end) begin
                check_acc = check_acc ^ rx;
            end
            frame_count = frame_count + 17'd1;
            if (in_header || frame_count <= {1'b0, active_cfg.store_limit}) begin
                slot = frame_count - 17'd1;
                r.store_valid = 1'b1;
                r.store_index = slot[15:0];
                r.store_value = rx;
            end
            if (r.frame_end) begin
                clear_frame_state();
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                results_due.push_back(deframe_byte(s_rx_byte));
            end
            if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_rx_byte <= rx_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        nfr_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: result beat with nothing expected", $time);
                    end
                end else begin
                    want = results_due.pop_front();
                    check_field("store_valid", 16'(want.store_valid), 16'(m_store_valid));
                    check_field("store_index", want.store_index, m_store_index);
                    check_field("store_value", 16'(want.store_value), 16'(m_store_value));
                    check_field("frame_end", 16'(want.frame_end), 16'(m_frame_end));
                    check_field("frame_status", 16'(want.frame_status),
                                16'(m_frame_status));
                    check_field("payload_length", want.payload_length, m_payload_length);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void push_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endfunction

    function automatic logic [7:0] non_start_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == active_cfg.start_byte_value) begin
            b = b + 8'd1;
        end
        return b;
    endfunction

    function automatic void push_noise(input int count);
        for (int i = 0; i < count; i++) begin
            push_byte(non_start_byte());
        end
    endfunction

    function automatic void push_frame(input logic [15:0] len, input bit good);
        logic [7:0] fcs;
        logic [7:0] b;
        push_byte(active_cfg.start_byte_value);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        fcs = len[7:0] ^ len[15:8];
        for (int i = 0; i < len + 2; i++) begin
            b = 8'($urandom_range(255));
            fcs = fcs ^ b;
            push_byte(b);
        end
        push_byte(good ? fcs : fcs ^ 8'($urandom_range(1, 255)));
    endfunction

    function automatic void push_random_traffic(input int count);
        int first;
        int pick;
        int len_pick;
        logic [15:0] len;
        first = bytes_queued;
        while (bytes_queued - first < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                push_noise($urandom_range(0, active_cfg.hunt_limit - 1));
                len_pick = $urandom_range(99);
                if (len_pick < 60) begin
                    len = 16'($urandom_range(0, 6));
                end else if (len_pick < 90) begin
                    len = 16'($urandom_range(7, 40));
                end else begin
                    len = 16'($urandom_range(41, 300));
                end
                push_frame(len, $urandom_range(99) < 85);
            end else if (pick < 82) begin
                push_noise(int'(active_cfg.hunt_limit));
                push_byte($urandom_range(1) ? active_cfg.start_byte_value : non_start_byte());
            end else if (pick < 92) begin
                push_noise($urandom_range(0, active_cfg.hunt_limit - 1));
                push_byte(active_cfg.start_byte_value);
                push_byte(8'($urandom_range(255)));
                push_byte(8'd0);
                push_noise($urandom_range(0, 3));
            end else begin
                push_noise($urandom_range(1, 20));
            end
        end
    endfunction

    task automatic write_reg(input logic [nfr_pkg::CfgIndexWidth-1:0] idx,
                             input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            nfr_pkg::CFG_START_BYTE:  active_cfg.start_byte_value = value[7:0];
            nfr_pkg::CFG_HUNT_LIMIT:  active_cfg.hunt_limit = value[3:0];
            nfr_pkg::CFG_STORE_LIMIT: active_cfg.store_limit = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] start_value, input logic [3:0] hunt,
                                  input logic [15:0] store);
        write_reg(nfr_pkg::CFG_START_BYTE, {8'd0, start_value});
        write_reg(nfr_pkg::CFG_HUNT_LIMIT, {12'd0, hunt});
        write_reg(nfr_pkg::CFG_STORE_LIMIT, store);
    endtask

    task automatic wait_all_results();
        while (results_seen != bytes_queued) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening with the reset settings.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_frame(16'd0, 1'b1);
        for (int i = 1; i <= 9; i++) begin
            push_byte(8'(i));
        end
        push_byte(active_cfg.start_byte_value);
        push_frame(16'd1, 1'b0);
        push_random_traffic(PHASE_BYTES);
        wait_all_results();

        for (int ph = 1; ph < 9; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 48;
            end else if (ph < 6) begin
                send_idle_pct = 48;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: apply_settings(8'h00, 4'd1, 16'd5);
                2: apply_settings(8'hFF, 4'd15, 16'hFFFF);
                3: apply_settings(8'hA5, 4'd4, 16'd12);
                default: apply_settings(8'($urandom_range(255)), 4'($urandom_range(1, 15)),
                                        ($urandom_range(99) < 70) ?
                                        16'($urandom_range(5, 40)) :
                                        16'($urandom_range(41, 65535)));
            endcase
            push_random_traffic(PHASE_BYTES);
            wait_all_results();
        end

        // Short frames at the smallest buffer, so payload and check bytes cross the limit.
        apply_settings(8'h5A, 4'd15, 16'd5);
        push_frame(16'd0, 1'b1);
        push_frame(16'd3, 1'b1);
        push_random_traffic(20);
        wait_all_results();

        if (results_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, results_due.size());
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
